/* hw/rtl/image_header_tag_scanner_macros.svh */
// ----------------------------------------------------------------------------
// image header tag scanner assertion macros
// Concurrent check helpers clocked on clk and held off during rst_n.
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_TAG_SCANNER_MACROS_SVH
`define IMAGE_HEADER_TAG_SCANNER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IHTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihts check failed");

// next-cycle implication
`define IHTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihts check failed");

`else

`define IHTS_ASSERT_NOW(label, ante, cons)
`define IHTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/ihts_pkg.sv */
// ----------------------------------------------------------------------------
// ihts_pkg
// Shared widths, tag values, stage and kind codes and the result type.
// ----------------------------------------------------------------------------
`default_nettype none

package ihts_pkg;

  localparam int OFFSET_BITS_DEF = 24;
  localparam int BYTE_W          = 8;
  localparam int WORD_W          = 16;
  localparam int OFF_W           = 24;
  localparam int KIND_W          = 2;
  localparam int DIM_STAGE_W     = 3;
  localparam int HDR_STAGE_W     = 2;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  // tag words
  localparam logic [WORD_W-1:0] TAG_GROUP    = 16'd40;
  localparam logic [WORD_W-1:0] TAG_ROWS     = 16'd16;
  localparam logic [WORD_W-1:0] TAG_COLS     = 16'd17;
  localparam logic [WORD_W-1:0] TAG_PIXGROUP = 16'd32736;
  localparam logic [WORD_W-1:0] TAG_PIXDATA  = 16'd16;

  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

  // result kinds
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_ROWS   = 2'd0;
  localparam kind_t KIND_COLS   = 2'd1;
  localparam kind_t KIND_HEADER = 2'd2;

  // row / column matcher stages
  localparam logic [DIM_STAGE_W-1:0] DIM_SEARCH = 3'd0;
  localparam logic [DIM_STAGE_W-1:0] DIM_WORD1  = 3'd1;
  localparam logic [DIM_STAGE_W-1:0] DIM_WORD2  = 3'd2;
  localparam logic [DIM_STAGE_W-1:0] DIM_WORD3  = 3'd3;
  localparam logic [DIM_STAGE_W-1:0] DIM_DONE   = 3'd4;

  // header matcher stages
  localparam logic [HDR_STAGE_W-1:0] HDR_SEARCH = 2'd0;
  localparam logic [HDR_STAGE_W-1:0] HDR_WORD1  = 2'd1;
  localparam logic [HDR_STAGE_W-1:0] HDR_WORD2  = 2'd2;
  localparam logic [HDR_STAGE_W-1:0] HDR_DONE   = 2'd3;

  // configuration register index
  localparam logic [0:0] REG_SWAP_BYTES = 1'b0;

  typedef struct packed {
    logic                     valid;
    kind_t                    kind;
    logic signed [WORD_W-1:0] word_value;
    logic [OFF_W-1:0]         byte_offset;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/ihts_in_if.sv */
// ----------------------------------------------------------------------------
// ihts_in_if
// Byte stream channel: valid/ready with the data byte and restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihts_in_if;
  import ihts_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ihts_out_if.sv */
// ----------------------------------------------------------------------------
// ihts_out_if
// Result channel: valid/ready with kind, word value and byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface ihts_out_if;
  import ihts_pkg::*;

  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic signed [WORD_W-1:0] word_value;
  logic [OFF_W-1:0]         byte_offset;

  modport source (output valid, output kind, output word_value, output byte_offset,
                  input ready);
  modport sink   (input valid, input kind, input word_value, input byte_offset,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/ihts_apb_regs.sv */
// ----------------------------------------------------------------------------
// ihts_apb_regs
// APB-style register file holding the byte order control.
// ----------------------------------------------------------------------------
`default_nettype none

module ihts_apb_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ihts_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ihts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ihts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output logic                                swap_bytes
);
  import ihts_pkg::*;

  logic swap_r;
  logic swap_nxt;
  logic sel_swap;

  // word address decode, one register
  assign sel_swap = (paddr[CFG_ADDR_W-1] == REG_SWAP_BYTES);

  // write on the access phase of a transfer
  always_comb begin
    swap_nxt = swap_r;
    if (psel && penable && pwrite && sel_swap) begin
      swap_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b1;
    end else begin
      swap_r <= swap_nxt;
    end
  end

  // read back
  assign prdata     = sel_swap ? {{(CFG_DATA_W-1){1'b0}}, swap_r} : '0;
  assign pready     = 1'b1;
  assign swap_bytes = swap_r;

endmodule

`default_nettype wire

/* hw/rtl/ihts_scan_core.sv */
// ----------------------------------------------------------------------------
// ihts_scan_core
// Input register, word assembly, byte counter and the three tag matchers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_header_tag_scanner_macros.svh"

module ihts_scan_core #(
  parameter int OFFSET_BITS = ihts_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ihts_pkg::BYTE_W-1:0] in_data_byte,
  input  wire logic                        in_restart,
  input  wire logic                        swap_bytes,
  input  wire logic                        res_ready,
  output ihts_pkg::res_t                   res
);
  import ihts_pkg::*;

  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  typedef struct packed {
    logic [DIM_STAGE_W-1:0] stage;
    logic                   report;
  } dim_step_t;

  typedef struct packed {
    logic [HDR_STAGE_W-1:0] stage;
    logic                   report;
  } hdr_step_t;

  // row / column matcher step
  function automatic dim_step_t dim_step(input logic [DIM_STAGE_W-1:0] stage,
                                         input logic hit);
    dim_step_t s;
    s.stage  = stage;
    s.report = 1'b0;
    unique case (stage)
      DIM_SEARCH: s.stage = hit ? DIM_WORD1 : DIM_SEARCH;
      DIM_WORD1:  s.stage = DIM_WORD2;
      DIM_WORD2:  s.stage = DIM_WORD3;
      DIM_WORD3: begin
        s.stage  = DIM_DONE;
        s.report = 1'b1;
      end
      default:    s.stage = stage;
    endcase
    return s;
  endfunction

  // header matcher step
  function automatic hdr_step_t hdr_step(input logic [HDR_STAGE_W-1:0] stage,
                                         input logic hit);
    hdr_step_t s;
    s.stage  = stage;
    s.report = 1'b0;
    unique case (stage)
      HDR_SEARCH: s.stage = hit ? HDR_WORD1 : HDR_SEARCH;
      HDR_WORD1:  s.stage = HDR_WORD2;
      HDR_WORD2: begin
        s.stage  = HDR_DONE;
        s.report = 1'b1;
      end
      default:    s.stage = stage;
    endcase
    return s;
  endfunction

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_restart_r;
  logic              advance;

  // scan state
  logic [OFFSET_BITS-1:0] count_r, count_nxt;
  logic [BYTE_W-1:0]      held_r, held_nxt;
  logic                   phase_r, phase_nxt;
  logic [WORD_W-1:0]      prev_r, prev_nxt;
  logic                   prev_valid_r, prev_valid_nxt;
  logic [DIM_STAGE_W-1:0] rows_r, rows_nxt;
  logic [DIM_STAGE_W-1:0] cols_r, cols_nxt;
  logic [HDR_STAGE_W-1:0] hdr_r, hdr_nxt;

  // state as seen by the item after an optional restart
  logic [OFFSET_BITS-1:0] cur_count;
  logic [BYTE_W-1:0]      cur_held;
  logic                   cur_phase;
  logic [WORD_W-1:0]      cur_prev;
  logic                   cur_prev_valid;
  logic [DIM_STAGE_W-1:0] cur_rows;
  logic [DIM_STAGE_W-1:0] cur_cols;
  logic [HDR_STAGE_W-1:0] cur_hdr;

  logic [OFFSET_BITS-1:0] count_inc;
  logic [WORD_W-1:0]      word;
  logic                   grp_hit, pix_hit;
  dim_step_t              rows_s, cols_s;
  hdr_step_t              hdr_s;
  logic [31:0]            count_ext;
  logic [OFF_W-1:0]       off_sat;

  // the held item moves on when the result buffer can take a result
  assign advance      = s1_valid_r && res_ready;
  assign in_ready     = !s1_valid_r || res_ready;
  assign s1_valid_nxt = in_valid ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r    <= in_data_byte;
      s1_restart_r <= in_restart;
    end
  end

  // restart clears the scan state before the byte is used
  always_comb begin
    cur_count      = s1_restart_r ? '0 : count_r;
    cur_held       = s1_restart_r ? '0 : held_r;
    cur_phase      = s1_restart_r ? 1'b0 : phase_r;
    cur_prev       = s1_restart_r ? '0 : prev_r;
    cur_prev_valid = s1_restart_r ? 1'b0 : prev_valid_r;
    cur_rows       = s1_restart_r ? DIM_SEARCH : rows_r;
    cur_cols       = s1_restart_r ? DIM_SEARCH : cols_r;
    cur_hdr        = s1_restart_r ? HDR_SEARCH : hdr_r;
  end

  // saturating byte counter
  assign count_inc = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

  // word assembly
  assign word = swap_bytes ? {s1_byte_r, cur_held} : {cur_held, s1_byte_r};

  // tag pair compares
  assign grp_hit = cur_prev_valid && (cur_prev == TAG_GROUP);
  assign pix_hit = cur_prev_valid && (cur_prev == TAG_PIXGROUP) && (word == TAG_PIXDATA);

  always_comb begin
    rows_s = dim_step(cur_rows, grp_hit && (word == TAG_ROWS));
    cols_s = dim_step(cur_cols, grp_hit && (word == TAG_COLS));
    hdr_s  = hdr_step(cur_hdr, pix_hit);
  end

  // header length limited to the field width
  assign count_ext = 32'(count_inc);
  assign off_sat   = (count_ext > 32'(OFF_MAX)) ? OFF_MAX : count_ext[OFF_W-1:0];

  // next state and result
  always_comb begin
    count_nxt      = count_r;
    held_nxt       = held_r;
    phase_nxt      = phase_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    hdr_nxt        = hdr_r;
    res            = '0;
    if (advance) begin
      count_nxt = count_inc;
      if (!cur_phase) begin
        held_nxt       = s1_byte_r;
        phase_nxt      = 1'b1;
        prev_nxt       = cur_prev;
        prev_valid_nxt = cur_prev_valid;
        rows_nxt       = cur_rows;
        cols_nxt       = cur_cols;
        hdr_nxt        = cur_hdr;
      end else begin
        held_nxt       = cur_held;
        phase_nxt      = 1'b0;
        prev_nxt       = word;
        prev_valid_nxt = 1'b1;
        rows_nxt       = rows_s.stage;
        cols_nxt       = cols_s.stage;
        hdr_nxt        = hdr_s.stage;
        // rows over columns over header
        priority if (rows_s.report) begin
          res.valid      = 1'b1;
          res.kind       = KIND_ROWS;
          res.word_value = signed'(word);
        end else if (cols_s.report) begin
          res.valid      = 1'b1;
          res.kind       = KIND_COLS;
          res.word_value = signed'(word);
        end else if (hdr_s.report) begin
          res.valid       = 1'b1;
          res.kind        = KIND_HEADER;
          res.byte_offset = off_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      held_r       <= '0;
      phase_r      <= 1'b0;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      rows_r       <= DIM_SEARCH;
      cols_r       <= DIM_SEARCH;
      hdr_r        <= HDR_SEARCH;
    end else begin
      count_r      <= count_nxt;
      held_r       <= held_nxt;
      phase_r      <= phase_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      rows_r       <= rows_nxt;
      cols_r       <= cols_nxt;
      hdr_r        <= hdr_nxt;
    end
  end

  // results only come from the second byte of a word
  `IHTS_ASSERT_NOW(a_res_on_word, res.valid, advance && cur_phase)
  // a finished row matcher stays finished until a restart goes through
  `IHTS_ASSERT_NEXT(a_rows_done_holds, (rows_r == DIM_DONE) && !(advance && s1_restart_r),
                    rows_r == DIM_DONE)
  // a finished header matcher stays finished until a restart goes through
  `IHTS_ASSERT_NEXT(a_hdr_done_holds, (hdr_r == HDR_DONE) && !(advance && s1_restart_r),
                    hdr_r == HDR_DONE)
  // the byte counter never falls without a restart
  `IHTS_ASSERT_NEXT(a_count_no_fall, !(advance && s1_restart_r), count_r >= $past(count_r))

endmodule

`default_nettype wire

/* hw/rtl/ihts_out_buf.sv */
// ----------------------------------------------------------------------------
// ihts_out_buf
// Result register between the scan core and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ihts_out_buf (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  ihts_pkg::res_t                       res,
  output logic                                 res_ready,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output ihts_pkg::kind_t                      out_kind,
  output logic signed [ihts_pkg::WORD_W-1:0]   out_word_value,
  output logic        [ihts_pkg::OFF_W-1:0]    out_byte_offset
);
  import ihts_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  // free when empty or being drained this cycle
  assign res_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = data_r.kind;
  assign out_word_value  = data_r.word_value;
  assign out_byte_offset = data_r.byte_offset;

endmodule

`default_nettype wire

/* hw/rtl/image_header_tag_scanner.sv */
// ----------------------------------------------------------------------------
// image_header_tag_scanner
// Scans an image file byte stream for the row, column and header length tags.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+------------------------------------
//   in_if    | in  | valid / ready    | data_byte[7:0], restart
//   out_if   | out | valid / ready    | kind[1:0], word_value[15:0] signed,
//            |     |                  | byte_offset[23:0]
//   cfg_*    | in  | APB write/read   | reg 0 swap_bytes at byte address 0
//
// One byte per cycle sustained while out_if.ready holds; a result passes
// the input register, then the result register, before out_if offers it.
// Word assembly, tag compare and counter increment all sit in the one
// combinational path between those two registers.
// Synchronous active-low reset; swap_bytes resets to 1, scan state to zero.
// A full result register that is not drained holds the byte in the input
// register, and in_if.ready drops until out_if.ready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module image_header_tag_scanner #(
  parameter int OFFSET_BITS = ihts_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ihts_in_if.sink                              in_if,
  ihts_out_if.source                           out_if,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [ihts_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [ihts_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [ihts_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import ihts_pkg::*;

  logic swap_bytes;
  logic res_ready;
  res_t res;

  // configuration registers
  ihts_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .swap_bytes (swap_bytes)
  );

  // input register and matchers
  ihts_scan_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_data_byte (in_if.data_byte),
    .in_restart   (in_if.restart),
    .swap_bytes   (swap_bytes),
    .res_ready    (res_ready),
    .res          (res)
  );

  // result register
  ihts_out_buf u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .res_ready       (res_ready),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_kind        (out_if.kind),
    .out_word_value  (out_if.word_value),
    .out_byte_offset (out_if.byte_offset)
  );

endmodule

`default_nettype wire
